/* sv/saturating_mix_ring_buffer_top_macros.svh */
// Assertion macros for the saturating mix ring buffer checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef SATURATING_MIX_RING_BUFFER_TOP_MACROS_SVH
`define SATURATING_MIX_RING_BUFFER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SMRB_ASSERT_IMPL(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("smrb: assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define SMRB_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("smrb: assertion failed");

`endif

/* sv/smrb_pkg.sv */
// Shared types and constants of the saturating mix ring buffer.
// No dependencies; imported by every RTL module of the block.
package smrb_pkg;

	// Operation carried in tuser
	typedef enum logic {
		OP_MIX  = 1'b0,
		OP_READ = 1'b1
	} smrb_op_t;

	// Classified command handed from front to back
	typedef struct packed {
		smrb_op_t           op;
		logic signed [15:0] sample;
	} smrb_cmd_t;

	localparam int unsigned CMD_W  = $bits(smrb_cmd_t);

	// Small decoupling queues
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = 2;

	// Symmetric clip limits
	localparam logic signed [16:0] CLIP_HIGH = 17'sd32767;
	localparam logic signed [16:0] CLIP_LOW  = -17'sd32767;

endpackage

/* sv/saturating_mix_ring_buffer_top.sv */
// Top level of the saturating mix ring buffer: front, command queue, back
// and output queue. Depends on smrb_pkg, smrb_front, smrb_fifo, smrb_back.
//
//  Channel   Dir  tdata (low bit up)                    tuser
//  s_        in   sample_value[15:0], offset[31:16]     operation
//  m_        out  out_sample[15:0]                      -
//
// One transaction per cycle sustained; the single memory read-modify-write
// of the back part, with forwarding, sets that figure.
// Path: 1 capture stage, offset reduction stages (none when DEPTH >= 65536),
// queue, memory read stage, output queue.
// After reset a clearing pass zeroes the memory; s_tready stays low until
// it ends. Each side stalls on its own behind its queue.
module saturating_mix_ring_buffer_top #(
	parameter int unsigned DEPTH = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [31:0]        s_tdata,   // sample_value[15:0], offset[31:16]
	input  logic [0:0]         s_tuser,   // operation[0]
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic signed [15:0] m_tdata    // out_sample[15:0]
);
	import smrb_pkg::*;

	localparam int unsigned AW  = $clog2(DEPTH);
	localparam int unsigned IQW = CMD_W + AW;

	logic            fe_push;
	smrb_cmd_t       fe_cmd;
	logic [AW-1:0]   fe_rem;
	logic            iq_full;
	logic            iq_valid;
	logic            iq_pop;
	logic [IQW-1:0]  iq_data;
	logic [QAW:0]    iq_cnt;
	smrb_cmd_t       be_cmd;
	logic [AW-1:0]   be_rem;
	logic            clr_busy;
	logic            res_push;
	logic [15:0]     res_data;
	logic            oq_full;
	logic [QAW:0]    oq_cnt;
	logic [15:0]     oq_data;

	smrb_front #(.DEPTH(DEPTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.clr_busy (clr_busy),
		.q_full   (iq_full),
		.push     (fe_push),
		.push_cmd (fe_cmd),
		.push_rem (fe_rem)
	);

	// Command queue between front and back
	smrb_fifo #(.W(IQW)) u_cmd_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fe_push),
		.push_data ({fe_rem, fe_cmd}),
		.pop       (iq_pop),
		.pop_data  (iq_data),
		.valid     (iq_valid),
		.full      (iq_full),
		.count     (iq_cnt)
	);

	assign be_cmd = smrb_cmd_t'(iq_data[CMD_W-1:0]);
	assign be_rem = iq_data[CMD_W +: AW];

	smrb_back #(.DEPTH(DEPTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (iq_valid && (iq_cnt != '0)),
		.q_cmd    (be_cmd),
		.q_rem    (be_rem),
		.q_pop    (iq_pop),
		.oq_cnt   (oq_cnt),
		.res_push (res_push),
		.res_data (res_data),
		.clr_busy (clr_busy)
	);

	// Output queue decouples the result side
	smrb_fifo #(.W(16)) u_out_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push && !oq_full),
		.push_data (res_data),
		.pop       (m_tvalid && m_tready),
		.pop_data  (oq_data),
		.valid     (m_tvalid),
		.full      (oq_full),
		.count     (oq_cnt)
	);

	assign m_tdata = oq_data;

endmodule

/* sv/smrb_fifo.sv */
// Four-entry register queue of generic width.
// Depends on smrb_pkg for the queue depth.
module smrb_fifo #(
	parameter int unsigned W = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  logic [W-1:0]              push_data,
	input  logic                      pop,
	output logic [W-1:0]              pop_data,
	output logic                      valid,
	output logic                      full,
	output logic [smrb_pkg::QAW:0]    count
);
	import smrb_pkg::*;

	logic [W-1:0]   mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   cnt_q;

	assign valid    = (cnt_q != '0);
	assign full     = (cnt_q == (QAW + 1)'(QDEPTH));
	assign count    = cnt_q;
	assign pop_data = mem_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// Payload storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

/* sv/smrb_front.sv */
// Front part: accepts transactions, classifies them and reduces the offset
// modulo DEPTH in a compare-subtract pipeline. Depends on smrb_pkg.
module smrb_front #(
	parameter int unsigned DEPTH = 65536,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [0:0]          s_tuser,
	input  logic [31:0]         s_tdata,
	input  logic                clr_busy,
	input  logic                q_full,
	output logic                push,
	output smrb_pkg::smrb_cmd_t push_cmd,
	output logic [AW-1:0]       push_rem
);
	import smrb_pkg::*;

	// Number of conditional subtract steps that bring a 16-bit offset below DEPTH
	function automatic int calc_nstep(longint d);
		int n;
		n = 0;
		for (int k = 0; k < 16; k++)
			if ((d << k) <= 65535)
				n++;
		return n;
	endfunction

	localparam int NSTEP = calc_nstep(longint'(DEPTH));

	// Multiple of DEPTH removed in step j
	function automatic logic [16:0] step_sub(int j);
		return 17'(longint'(DEPTH) << (NSTEP - j));
	endfunction

	logic        v_s   [0:NSTEP];
	smrb_cmd_t   cmd_s [0:NSTEP];
	logic [15:0] rem_s [0:NSTEP];
	logic        en;

	// Whole pipeline holds when its last stage cannot enter the queue
	assign en       = !(v_s[NSTEP] && q_full);
	assign s_tready = en && !clr_busy;
	assign push     = en && v_s[NSTEP];
	assign push_cmd = cmd_s[NSTEP];
	assign push_rem = AW'(rem_s[NSTEP]);

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= NSTEP; j++)
				v_s[j] <= 1'b0;
		end else if (en) begin
			v_s[0] <= s_tvalid && s_tready;
			for (int j = 1; j <= NSTEP; j++)
				v_s[j] <= v_s[j-1];
		end
	end

	// Stage payload: capture, then one compare-subtract per stage
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s[0].op     <= smrb_op_t'(s_tuser);
			cmd_s[0].sample <= s_tdata[15:0];
			rem_s[0]        <= s_tdata[31:16];
			for (int j = 1; j <= NSTEP; j++) begin
				cmd_s[j] <= cmd_s[j-1];
				if ({1'b0, rem_s[j-1]} >= step_sub(j))
					rem_s[j] <= rem_s[j-1] - 16'(step_sub(j));
				else
					rem_s[j] <= rem_s[j-1];
			end
		end
	end

endmodule

/* sv/smrb_back.sv */
// Back part: read position, sample memory with one read-modify-write per
// cycle, forwarding, saturating add and the clearing pass. Depends on smrb_pkg.
module smrb_back #(
	parameter int unsigned DEPTH = 65536,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	input  smrb_pkg::smrb_cmd_t     q_cmd,
	input  logic [AW-1:0]           q_rem,
	output logic                    q_pop,
	input  logic [smrb_pkg::QAW:0]  oq_cnt,
	output logic                    res_push,
	output logic signed [15:0]      res_data,
	output logic                    clr_busy
);
	import smrb_pkg::*;

	logic signed [15:0] mem [DEPTH];

	logic [AW-1:0]      pos_q;
	logic               clr_busy_q;
	logic [AW-1:0]      clr_addr_q;

	logic               v_s2;
	smrb_op_t           op_s2;
	logic signed [15:0] smp_s2;
	logic [AW-1:0]      addr_s2;
	logic               fwd_s2;
	logic signed [15:0] fwd_data_s2;
	logic signed [15:0] rd_data_s2;

	logic [AW:0]        idx_sum;
	logic [AW-1:0]      idx_mix;
	logic [AW-1:0]      addr_b1;
	logic               rd_inflight;
	logic               room;
	logic signed [15:0] old_s2;
	logic signed [16:0] sum_s2;
	logic signed [15:0] new_s2;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic signed [15:0] wr_data;

	assign clr_busy = clr_busy_q;

	// Target entry: read position plus reduced offset, one wrap
	assign idx_sum = {1'b0, pos_q} + {1'b0, q_rem};
	assign idx_mix = (idx_sum >= (AW + 1)'(DEPTH)) ? AW'(idx_sum - (AW + 1)'(DEPTH))
	                                               : AW'(idx_sum);
	assign addr_b1 = (q_cmd.op == OP_READ) ? pos_q : idx_mix;

	// Issue a read only when the output queue has a slot for it
	assign rd_inflight = v_s2 && (op_s2 == OP_READ);
	assign room  = ({1'b0, oq_cnt} + (QAW + 2)'(rd_inflight)) < (QAW + 2)'(QDEPTH);
	assign q_pop = q_valid && !clr_busy_q && ((q_cmd.op == OP_MIX) || room);

	// Execute stage: forwarded or stored value, clipped sum (zero for a read)
	assign old_s2 = fwd_s2 ? fwd_data_s2 : rd_data_s2;
	assign sum_s2 = {smp_s2[15], smp_s2} + {old_s2[15], old_s2};

	always_comb begin
		if (op_s2 == OP_READ)
			new_s2 = '0;
		else if (sum_s2 > CLIP_HIGH)
			new_s2 = CLIP_HIGH[15:0];
		else if (sum_s2 < CLIP_LOW)
			new_s2 = CLIP_LOW[15:0];
		else
			new_s2 = sum_s2[15:0];
	end

	assign res_push = v_s2 && (op_s2 == OP_READ);
	assign res_data = old_s2;

	// Write port: clearing pass or write-back
	assign wr_en   = clr_busy_q || v_s2;
	assign wr_addr = clr_busy_q ? clr_addr_q : addr_s2;
	assign wr_data = clr_busy_q ? 16'sd0 : new_s2;

	// Sample memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_data_s2 <= mem[addr_b1];
	end

	// Control: read position, clearing pass, stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			v_s2       <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(DEPTH - 1))
					clr_busy_q <= 1'b0;
			end
			v_s2 <= q_pop;
			if (q_pop && (q_cmd.op == OP_READ))
				pos_q <= (pos_q == AW'(DEPTH - 1)) ? '0 : pos_q + 1'b1;
		end
	end

	// Stage payload and forward of the write still in flight
	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_s2       <= q_cmd.op;
			smp_s2      <= q_cmd.sample;
			addr_s2     <= addr_b1;
			fwd_s2      <= v_s2 && (addr_s2 == addr_b1);
			fwd_data_s2 <= new_s2;
		end
	end

endmodule

/* sv/smrb_checker.sv */
// Port-level checker for the saturating mix ring buffer, bound to the top.
// Depends on saturating_mix_ring_buffer_top_macros.svh.
`include "saturating_mix_ring_buffer_top_macros.svh"

module smrb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [0:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	logic [7:0] pend_q;
	logic       rd_in;
	logic       rd_out;

	assign rd_in  = s_tvalid && s_tready && s_tuser[0];
	assign rd_out = m_tvalid && m_tready;

	// Read transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else if (rd_in && !rd_out)
			pend_q <= pend_q + 1'b1;
		else if (rd_out && !rd_in)
			pend_q <= pend_q - 1'b1;
	end

	`SMRB_ASSERT_IMPL(a_never_most_neg, clk, arst_n, m_tvalid, m_tdata != 16'h8000)
	`SMRB_ASSERT_IMPL(a_result_owed, clk, arst_n, m_tvalid, pend_q != 8'd0)
	`SMRB_ASSERT_NEXT(a_valid_holds, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`SMRB_ASSERT_NEXT(a_data_holds, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))

endmodule

bind saturating_mix_ring_buffer_top smrb_checker u_smrb_checker (.*);
